// File: design/rast_pkg.sv
package rast_pkg;

	// Default parameter values
	localparam int FRACTION_BITS_DEF = 10;
	localparam int COORD_BITS_DEF    = 16;

	// Fixed field widths of the stream payloads
	localparam int COORD_W    = 16;
	localparam int COLOR_W    = 32;
	localparam int DIM_W      = 12;
	localparam int ADDR_W     = 24;
	localparam int KIND_W     = 3;
	localparam int IN_DATA_W  = 4 * COORD_W + COLOR_W;
	localparam int OUT_DATA_W = ADDR_W + COLOR_W + 2 * DIM_W;
	localparam int CFG_IDX_W  = 1;

	// Register reset values
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd800;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd600;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT = 3'd0,
		KIND_REJECT = 3'd1,
		KIND_WRITE  = 3'd2,
		KIND_CLIP   = 3'd3,
		KIND_IDLE   = 3'd4
	} kind_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DIV  = 1'b1
	} state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// File: design/rast_div.sv
module rast_div
	import rast_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [COORD_BITS-1:0]    dividend,   // never larger than divisor
	input  logic [COORD_BITS-1:0]    divisor,
	output logic [FRACTION_BITS:0]   quotient,   // valid while sts.done
	output div_sts_t                 sts
);

	localparam int CNT_W = $clog2(FRACTION_BITS + 1);
	localparam int REM_W = COORD_BITS + 1;

	logic [REM_W-1:0]         rem_q;
	logic [COORD_BITS-1:0]    div_q;
	logic [FRACTION_BITS:0]   quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;

	logic [REM_W-1:0]         trial;
	logic [REM_W-1:0]         diff;
	logic                     qbit;
	logic                     last_iter;

	// One restoring step: shift the remainder (except on the integer bit), compare, subtract
	always_comb begin
		trial     = (cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
		qbit      = trial >= {1'b0, div_q};
		diff      = trial - {1'b0, div_q};
		last_iter = busy_q && (cnt_q == CNT_W'(FRACTION_BITS));
	end

	assign quotient = {quo_q[FRACTION_BITS-1:0], qbit};
	assign sts.busy = busy_q;
	assign sts.done = last_iter;

	// Control: run FRACTION_BITS+1 iterations after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_iter) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: hold the divisor, shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff : trial;
			quo_q <= {quo_q[FRACTION_BITS-1:0], qbit};
		end
	end

endmodule

// File: design/fixed_point_line_rasterizer.sv
// Every result is registered and presented in the cycle after its input transaction.
// Pixels stream at one per cycle while the output is not stalled. A line start holds
// off input while the slope comes from a restoring divider that retires one quotient
// bit per cycle.
// Reset (arst_n low) clears the line state and output valid and restores 800 x 600.
module fixed_point_line_rasterizer
	import rast_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DIM_W-1:0]       cfg_wdata,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // start_x, start_y, end_x, end_y, draw_color
	input  logic                   s_tuser,   // operation
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // pixel_address, pixel_value, pixel_x, pixel_y
	output logic [KIND_W-1:0]      m_tuser,   // kind
	output logic                   m_tlast    // last_of_line
);

	localparam int PW    = COORD_BITS + 1;
	localparam int ACC_W = PW + FRACTION_BITS;
	localparam int CMP_W = ((PW > DIM_W) ? PW : DIM_W) + 1;

	// Registers
	state_t                   state_q, state_d;
	logic [DIM_W-1:0]         width_q, height_q;
	logic                     line_active_q;
	logic                     major_is_x_q;
	logic signed [PW-1:0]     major_pos_q, major_lim_q;
	logic signed [ACC_W-1:0]  acc_q, step_q;
	logic [COLOR_W-1:0]       color_q;
	logic                     neg_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;
	logic [KIND_W-1:0]        m_tuser_q;
	logic                     m_tlast_q;

	// Setup logic
	logic signed [PW-1:0]     xs, ys, xe, ye, dx, dy, ndx, ndy, dmaj, dmin, ms, me, ns;
	logic [COORD_BITS-1:0]    adx, ady, len, mag;
	logic                     zero_len, maj_x, swap;
	logic signed [ACC_W-1:0]  acc_init;

	// Step logic
	logic signed [PW-1:0]     minor, px, py;
	logic [CMP_W-1:0]         px_e, py_e, w_e, h_e;
	logic                     in_range, last;
	logic signed [PW:0]       pos_next, lim_e;
	logic [ADDR_W-1:0]        addr;

	// Result and handshake
	logic                     s_accept, is_start, div_start;
	logic [KIND_W-1:0]        res_kind;
	logic                     res_last;
	logic [OUT_DATA_W-1:0]    res_data;

	// Divider
	logic [FRACTION_BITS:0]   quo;
	logic [ACC_W-1:0]         quo_e;
	div_sts_t                 div_sts;

	assign s_accept = s_tvalid && s_tready;
	assign is_start = op_t'(s_tuser) == OP_START;

	// Endpoints: low COORD_BITS of each field, two's complement
	always_comb begin
		xs = {s_tdata[COORD_BITS-1], s_tdata[0 +: COORD_BITS]};
		ys = {s_tdata[COORD_W + COORD_BITS-1], s_tdata[COORD_W +: COORD_BITS]};
		xe = {s_tdata[2*COORD_W + COORD_BITS-1], s_tdata[2*COORD_W +: COORD_BITS]};
		ye = {s_tdata[3*COORD_W + COORD_BITS-1], s_tdata[3*COORD_W +: COORD_BITS]};
		dx  = xe - xs;
		dy  = ye - ys;
		ndx = -dx;
		ndy = -dy;
		adx = dx[PW-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ady = dy[PW-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		zero_len = (adx == '0) && (ady == '0);
		maj_x = adx > ady;
		dmaj  = maj_x ? dx : dy;
		dmin  = maj_x ? dy : dx;
		// swap endpoints when the major coordinate falls
		swap  = dmaj[PW-1];
		len   = maj_x ? adx : ady;
		mag   = maj_x ? ady : adx;
		ms    = swap ? (maj_x ? xe : ye) : (maj_x ? xs : ys);
		me    = swap ? (maj_x ? xs : ys) : (maj_x ? xe : ye);
		ns    = swap ? (maj_x ? ye : xe) : (maj_x ? ys : xs);
		acc_init = {ns, 1'b1, {(FRACTION_BITS-1){1'b0}}};
	end

	// Pixel position, clip test and address of the current step
	always_comb begin
		minor    = acc_q[ACC_W-1:FRACTION_BITS];
		px       = major_is_x_q ? major_pos_q : minor;
		py       = major_is_x_q ? minor : major_pos_q;
		px_e     = {{(CMP_W-PW){px[PW-1]}}, px};
		py_e     = {{(CMP_W-PW){py[PW-1]}}, py};
		w_e      = {{(CMP_W-DIM_W){1'b0}}, width_q};
		h_e      = {{(CMP_W-DIM_W){1'b0}}, height_q};
		in_range = !px[PW-1] && !py[PW-1] && (px_e < w_e) && (py_e < h_e);
		pos_next = {major_pos_q[PW-1], major_pos_q} + 1'b1;
		lim_e    = {major_lim_q[PW-1], major_lim_q};
		last     = pos_next >= lim_e;
		addr     = ADDR_W'(py_e[DIM_W-1:0]) * ADDR_W'(width_q) + ADDR_W'(px_e[DIM_W-1:0]);
	end

	// Result of the accepted transaction
	always_comb begin
		res_kind = KIND_IDLE;
		res_last = 1'b0;
		res_data = '0;
		if (is_start) begin
			res_kind = zero_len ? KIND_REJECT : KIND_ACCEPT;
		end else if (line_active_q) begin
			res_last = last;
			if (in_range) begin
				res_kind = KIND_WRITE;
				res_data = {py_e[DIM_W-1:0], px_e[DIM_W-1:0], color_q, addr};
			end else begin
				res_kind = KIND_CLIP;
			end
		end
	end

	// Sequencer
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready  = !m_tvalid_q || m_tready;
				div_start = s_tvalid && s_tready && is_start && !zero_len;
				if (div_start) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_sts.done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	rast_div #(
		.FRACTION_BITS (FRACTION_BITS),
		.COORD_BITS    (COORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (len),
		.quotient (quo),
		.sts      (div_sts)
	);

	assign quo_e = {{(ACC_W-FRACTION_BITS-1){1'b0}}, quo};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Line state: set up on start, advance on step, load slope when divider finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			major_is_x_q  <= 1'b0;
			major_pos_q   <= '0;
			major_lim_q   <= '0;
			acc_q         <= '0;
			step_q        <= '0;
			color_q       <= '0;
			neg_q         <= 1'b0;
		end else begin
			if (s_accept && is_start) begin
				line_active_q <= !zero_len;
				if (!zero_len) begin
					major_is_x_q <= maj_x;
					major_pos_q  <= ms;
					major_lim_q  <= me;
					acc_q        <= acc_init;
					color_q      <= s_tdata[4*COORD_W +: COLOR_W];
					neg_q        <= dmin[PW-1] ^ swap;
				end
			end else if (s_accept && line_active_q) begin
				major_pos_q <= major_pos_q + 1'b1;
				acc_q       <= acc_q + step_q;
				if (last) begin
					line_active_q <= 1'b0;
				end
			end
			if (div_sts.done) begin
				step_q <= neg_q ? -$signed(quo_e) : $signed(quo_e);
			end
		end
	end

	// Output register: one result per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata_q <= res_data;
			m_tuser_q <= res_kind;
			m_tlast_q <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// Divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == S_DIV)
		else $error("divider finished outside of slope computation");

	// A valid start holds off input until the slope is ready
	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == S_DIV && !s_tready && div_sts.busy)
		else $error("input taken during slope computation");

	// A rejected line leaves no active line behind
	a_reject_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && is_start && zero_len) |=> !line_active_q && m_tuser == KIND_REJECT)
		else $error("zero-length line left active");

	// Every accepted transaction presents a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> m_tvalid)
		else $error("result missing after accepted transaction");

endmodule

// File: dv/fixed_point_line_rasterizer_tb.sv
`timescale 1ns / 1ps
module fixed_point_line_rasterizer_tb;
	import rast_pkg::*;

	localparam int FRAC        = FRACTION_BITS_DEF;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE      = 3;
	localparam int PHASE_ITEMS = 50;

	typedef enum logic [1:0] {
		CMD_ITEM,
		CMD_DRAIN,
		CMD_REG
	} cmd_kind_t;

	typedef struct {
		cmd_kind_t          cmd;
		op_t                op;
		logic [COORD_W-1:0] xs;
		logic [COORD_W-1:0] ys;
		logic [COORD_W-1:0] xe;
		logic [COORD_W-1:0] ye;
		logic [COLOR_W-1:0] color;
		reg_idx_t           reg_sel;
		logic [DIM_W-1:0]   reg_val;
	} draw_cmd_t;

	typedef struct {
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic [DIM_W-1:0]   px;
		logic [DIM_W-1:0]   py;
		logic               last;
	} pixel_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	reg_idx_t              cfg_index = REG_IMAGE_WIDTH;
	logic [DIM_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;   // start_x, start_y, end_x, end_y, draw_color
	op_t                   s_tuser   = OP_START;   // operation
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;   // pixel_address, pixel_value, pixel_x, pixel_y
	logic [KIND_W-1:0]     m_tuser;   // kind
	logic                  m_tlast;   // last_of_line

	fixed_point_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Pending draw commands and predicted pixel results
	draw_cmd_t     draw_cmd_q[$];
	pixel_result_t pixel_exp_q[$];
	int            fails    = 0;
	int            idle_run = 0;

	// Raster and line state of the predictor
	logic [DIM_W-1:0]   raster_w = WIDTH_RESET;
	logic [DIM_W-1:0]   raster_h = HEIGHT_RESET;
	bit                 line_on  = 1'b0;
	bit                 major_x  = 1'b0;
	longint             major_pos = 0;
	longint             major_end = 0;
	longint             minor_acc = 0;
	longint             minor_inc = 0;
	logic [COLOR_W-1:0] line_rgb  = '0;

	// Handshake bookkeeping between the edges
	bit in_taken  = 1'b0;
	bit out_taken = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int quiet     = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Predict the result of one input transaction and advance the line state
	function automatic pixel_result_t rasterize(input op_t op, input logic [IN_DATA_W-1:0] d);
		pixel_result_t r;
		longint xs, ys, xe, ye, adx, ady, ms, me, ns, ne, t, minor, px, py;
		r = '{kind: KIND_IDLE, addr: '0, value: '0, px: '0, py: '0, last: 1'b0};
		if (op == OP_START) begin
			xs = longint'($signed(d[0 +: COORD_W]));
			ys = longint'($signed(d[COORD_W +: COORD_W]));
			xe = longint'($signed(d[2*COORD_W +: COORD_W]));
			ye = longint'($signed(d[3*COORD_W +: COORD_W]));
			adx = xe - xs;
			ady = ye - ys;
			if (adx < 0) adx = -adx;
			if (ady < 0) ady = -ady;
			line_on = 1'b0;
			if (adx == 0 && ady == 0) begin
				r.kind = KIND_REJECT;
				return r;
			end
			major_x = adx > ady;
			if (major_x) begin
				ms = xs; me = xe; ns = ys; ne = ye;
			end else begin
				ms = ys; me = ye; ns = xs; ne = xe;
			end
			// make the major coordinate rise
			if (ms > me) begin
				t = ms; ms = me; me = t;
				t = ns; ns = ne; ne = t;
			end
			// signed longint division truncates toward zero
			minor_inc = ((ne - ns) * (longint'(1) << FRAC)) / (me - ms);
			minor_acc = ns * (longint'(1) << FRAC) + (longint'(1) << (FRAC - 1));
			major_pos = ms;
			major_end = me;
			line_rgb  = d[4*COORD_W +: COLOR_W];
			line_on   = 1'b1;
			r.kind    = KIND_ACCEPT;
		end else if (line_on) begin
			minor  = minor_acc >>> FRAC;
			px     = major_x ? major_pos : minor;
			py     = major_x ? minor : major_pos;
			r.last = (major_pos + 1) >= major_end;
			if (px < 0 || py < 0 || px >= longint'(raster_w) || py >= longint'(raster_h)) begin
				r.kind = KIND_CLIP;
			end else begin
				r.kind  = KIND_WRITE;
				r.addr  = ADDR_W'(py * longint'(raster_w) + px);
				r.value = line_rgb;
				r.px    = DIM_W'(px);
				r.py    = DIM_W'(py);
			end
			major_pos++;
			minor_acc += minor_inc;
			if (r.last) line_on = 1'b0;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endfunction

	// Idle cycles before the next transaction; none during calm stretches
	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic void add_line(input int xs, input int ys, input int xe, input int ye,
			input logic [COLOR_W-1:0] color);
		draw_cmd_t c;
		c = '{cmd: CMD_ITEM, op: OP_START, xs: COORD_W'(xs), ys: COORD_W'(ys),
			xe: COORD_W'(xe), ye: COORD_W'(ye), color: color,
			reg_sel: REG_IMAGE_WIDTH, reg_val: '0};
		draw_cmd_q.push_back(c);
	endfunction

	function automatic void add_steps(input int n);
		draw_cmd_t c;
		c = '{cmd: CMD_ITEM, op: OP_STEP, xs: '0, ys: '0, xe: '0, ye: '0, color: '0,
			reg_sel: REG_IMAGE_WIDTH, reg_val: '0};
		for (int i = 0; i < n; i++) begin
			// keep the unused payload busy as well
			c.xs    = COORD_W'($urandom);
			c.color = $urandom;
			draw_cmd_q.push_back(c);
		end
	endfunction

	function automatic void add_marker(input cmd_kind_t kind, input reg_idx_t sel, input int val);
		draw_cmd_t c;
		c = '{cmd: kind, op: OP_STEP, xs: '0, ys: '0, xe: '0, ye: '0, color: '0,
			reg_sel: sel, reg_val: DIM_W'(val)};
		draw_cmd_q.push_back(c);
	endfunction

	// Coordinate near the low edge, near the high edge, or anywhere inside
	function automatic int near_edge(input int limit);
		case ($urandom_range(0, 2))
			0: return int'($urandom_range(0, 16)) - 6;
			1: return limit - 10 + int'($urandom_range(0, 16));
			default: return int'($urandom_range(0, limit));
		endcase
	endfunction

	// Mostly whole lines with random content, some noise and abandoned lines
	function automatic void random_burst(input int w, input int h, input int count);
		int made, xs, ys, xe, ye, span, n, pick;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				xs = near_edge(w);
				ys = near_edge(h);
				xe = xs + int'($urandom_range(0, 48)) - 24;
				ye = ys + int'($urandom_range(0, 48)) - 24;
				if ($urandom_range(0, 19) == 0) begin
					xe = xs;
					ye = ys;
				end
				span = (xe > xs ? xe - xs : xs - xe);
				n    = (ye > ys ? ye - ys : ys - ye);
				if (n > span) span = n;
				n = (pick < 2) ? int'($urandom_range(0, span)) : span + int'($urandom_range(0, 1));
				add_line(xs, ys, xe, ye, $urandom);
				add_steps(n);
				made += 1 + n;
			end else if (pick < 17) begin
				add_line($urandom, $urandom, $urandom, $urandom, $urandom);
				n = $urandom_range(0, 3);
				add_steps(n);
				made += 1 + n;
			end else if (pick < 19) begin
				n = $urandom_range(1, 3);
				add_steps(n);
				made += n;
			end else begin
				add_marker(CMD_DRAIN, REG_IMAGE_WIDTH, 0);
			end
		end
	endfunction

	// Present input transactions and register writes at the falling edge
	always @(negedge clk) begin
		draw_cmd_t            c;
		logic                 nv;
		logic                 nwe;
		logic [IN_DATA_W-1:0] nd;
		op_t                  nop;
		reg_idx_t             nidx;
		logic [DIM_W-1:0]     nval;
		nv   = s_tvalid && !in_taken;
		nwe  = 1'b0;
		nd   = s_tdata;
		nop  = s_tuser;
		nidx = cfg_index;
		nval = cfg_wdata;
		// quiet only once no result is pending and no slope is being computed
		if (pixel_exp_q.size() == 0 && !nv && s_tready) quiet++;
		else quiet = 0;
		if (arst_n && !nv) begin
			if (send_wait > 0) begin
				send_wait--;
			end else if (draw_cmd_q.size() != 0) begin
				c = draw_cmd_q[0];
				case (c.cmd)
					CMD_ITEM: begin
						void'(draw_cmd_q.pop_front());
						nv  = 1'b1;
						nd  = {c.color, c.ye, c.xe, c.ys, c.xs};
						nop = c.op;
						if ($urandom_range(0, 40) == 0) send_calm = !send_calm;
						send_wait = draw_gap(send_calm);
					end
					CMD_DRAIN: begin
						if (pixel_exp_q.size() == 0) void'(draw_cmd_q.pop_front());
					end
					default: begin
						// write only once the block has gone quiet
						if (quiet >= SETTLE) begin
							void'(draw_cmd_q.pop_front());
							nwe   = 1'b1;
							nidx  = c.reg_sel;
							nval  = c.reg_val;
							quiet = 0;
						end
					end
				endcase
			end
		end
		s_tvalid  <= nv;
		s_tdata   <= nd;
		s_tuser   <= nop;
		cfg_we    <= nwe;
		cfg_index <= nidx;
		cfg_wdata <= nval;
	end

	// Stall the result stream at random
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 40) == 0) recv_calm = !recv_calm;
			recv_wait = draw_gap(recv_calm);
		end
		if (recv_wait > 0) begin
			recv_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Track register writes, predict on input transactions, check result transactions
	always @(posedge clk) begin
		pixel_result_t want;
		bit            moved;
		moved = 1'b0;
		in_taken  <= arst_n && s_tvalid && s_tready;
		out_taken <= arst_n && m_tvalid && m_tready;
		if (arst_n) begin
			if (cfg_we) begin
				moved = 1'b1;
				case (cfg_index)
					REG_IMAGE_WIDTH:  raster_w = cfg_wdata;
					REG_IMAGE_HEIGHT: raster_h = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (pixel_exp_q.size() == 0) begin
					$error("unexpected result transaction, kind %0d", m_tuser);
					fails++;
				end else begin
					want = pixel_exp_q.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("last_of_line", want.last, m_tlast);
					check_field("pixel_address", want.addr, m_tdata[0 +: ADDR_W]);
					check_field("pixel_value", want.value, m_tdata[ADDR_W +: COLOR_W]);
					check_field("pixel_x", want.px, m_tdata[ADDR_W + COLOR_W +: DIM_W]);
					check_field("pixel_y", want.py, m_tdata[ADDR_W + COLOR_W + DIM_W +: DIM_W]);
				end
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				pixel_exp_q.push_back(rasterize(s_tuser, s_tdata));
			end
		end
		idle_run <= moved ? 0 : idle_run + 1;
	end

	// Abort when nothing has moved for too long
	initial begin
		while (idle_run < STALL_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int ws[8];
		int hs[8];
		ws = '{4095, 1, 0, 800, 64, 0, 3, int'(WIDTH_RESET)};
		hs = '{4095, 1, 600, 0, 48, 0, 4095, int'(HEIGHT_RESET)};
		ws[5] = $urandom_range(1, 4095);
		hs[5] = $urandom_range(1, 4095);

		// Directed lines on the reset raster
		add_steps(1);                                   // step with no line
		add_line(5, 5, 5, 5, 32'h1234_5678);            // zero length
		add_steps(1);
		add_line(10, 20, 14, 22, 32'hFFFF_FFFF);        // x major, rising
		add_steps(5);                                   // one step past the end
		add_line(30, 40, 28, 35, 32'h0000_0001);        // y major, swapped
		add_steps(5);
		add_line(100, 100, 103, 97, 32'h8000_0000);     // equal deltas go y major
		add_steps(3);
		add_line(-32768, -32768, 32767, 32767, 32'h0);  // extreme span, clipped
		add_steps(2);
		add_line(799, 599, 790, 599, 32'hA5A5_5A5A);    // abandons the previous line
		add_steps(9);
		add_marker(CMD_DRAIN, REG_IMAGE_WIDTH, 0);

		// Random phases over several raster sizes
		for (int p = 0; p < 8; p++) begin
			add_marker(CMD_REG, REG_IMAGE_WIDTH, ws[p]);
			add_marker(CMD_REG, REG_IMAGE_HEIGHT, hs[p]);
			random_burst(ws[p], hs[p], PHASE_ITEMS);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain everything, then watch for stray results
		while (draw_cmd_q.size() != 0 || s_tvalid || pixel_exp_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fails == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
